// ===== design/temperature_record_table_stats_defines.svh =====
// Assertion macros for the temperature record table.
// Used by the modules of the design folder; no other dependencies.
`ifndef TEMPERATURE_RECORD_TABLE_STATS_DEFINES_SVH
`define TEMPERATURE_RECORD_TABLE_STATS_DEFINES_SVH
`ifndef SYNTHESIS
`define TRTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TRTS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRTS_ASSERT(label, clk, rst, prop, msg)
`define TRTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/trts_pkg.sv =====
// Package for the temperature record table: types, codes, constants.
// No dependencies.
package trts_pkg;
   localparam int TableDepthDefault = 64;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_REMOVE     = 3'd2,
      ACT_MONTH      = 3'd3,
      ACT_ALL        = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [13:0]       rec_year;
      logic [7:0]        rec_month;
      logic [7:0]        rec_day;
      logic [7:0]        rec_hour;
      logic [7:0]        rec_minute;
      logic signed [7:0] rec_temp;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [6:0]         match_count;
      logic signed [7:0]  min_temp;
      logic signed [7:0]  max_temp;
      logic signed [15:0] avg_temp;
   } rsp_type;

   // table entry: year, month, day, hour, minute, temp = 42 bits
   typedef struct packed {
      logic [13:0]       year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic signed [7:0] temp;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_SCAN_RD, S_SCAN_CHK,
      S_DIV, S_DONE
   } state_type;
endpackage

// ===== design/trts_divider.sv =====
// Restoring divider, one quotient bit per cycle: (mag*256)/cnt.
// Depends on the defines header.
`include "temperature_record_table_stats_defines.svh"
module trts_divider #(
   parameter int CntW = 7,
   parameter int DivW = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DivW-1:0]   dividend,
   input  logic [CntW-1:0]   divisor,
   output logic              busy,
   output logic [DivW-1:0]   quotient
);
   localparam int RemW  = CntW + 1;
   localparam int StepW = $clog2(DivW);
   logic [DivW-1:0]  quo_ff, quo_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [StepW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [RemW-1:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[RemW-2:0], quo_ff[DivW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit and try subtract
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + StepW'(1);
         if (cnt_ff == StepW'(DivW - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   `TRTS_ASSERT(a_div_cnt, clock, reset, busy_ff |-> cnt_ff <= StepW'(DivW - 1), "divider overrun")
   `TRTS_ASSERT(a_div_done, clock, reset, (busy_ff && cnt_ff == StepW'(DivW - 1) && !start) |=> !busy_ff, "divider did not stop")
   `TRTS_ASSERT(a_div_rem, clock, reset, busy_ff |-> rem_ff < {1'b0, divisor}, "remainder not below divisor")
endmodule

// ===== design/temperature_record_table_stats.sv =====
// Top level of the temperature record table with statistics.
// Depends on trts_pkg, trts_divider and the defines header.
//
//  channel | ports                      | direction | payload
//  req     | req_valid, req_stall, req  | in        | trts_pkg::req_type
//  rsp     | rsp_valid, rsp_stall, rsp  | out       | trts_pkg::rsp_type
//
// Push back writes the new entry directly; push front first moves every entry
// up one slot (one read and one write of the single-port table memory per moved
// entry); remove and query walk the table, and a nonempty query ends with the
// bit-serial divide.
// Reset clears the count, the sequencer and rsp_valid; table contents stay undefined.
// req_stall is high whenever a transaction is in flight or a result waits.
// A stalled result holds in the output register until rsp_stall drops.
`include "temperature_record_table_stats_defines.svh"
module temperature_record_table_stats #(
   parameter int TABLE_DEPTH = trts_pkg::TableDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trts_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trts_pkg::rsp_type rsp
);
   localparam int AddrW = $clog2(TABLE_DEPTH);
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);
   // signed sum of up to TABLE_DEPTH temperatures of magnitude below 128
   localparam int SumW  = CntW + 8;
   // magnitude of the sum with 8 fraction bits appended
   localparam int DivW  = SumW + 7;

   // table memory: one port, registered read
   trts_pkg::entry_type mem [TABLE_DEPTH];
   trts_pkg::entry_type rd_ff;
   logic [AddrW-1:0]    mem_addr;
   logic                mem_we;
   trts_pkg::entry_type mem_wd;

   trts_pkg::state_type state_ff, state_in;
   trts_pkg::req_type   req_ff, req_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [CntW-1:0]     idx_ff, idx_in;
   logic [CntW-1:0]     mcnt_ff, mcnt_in;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic signed [7:0]   min_ff, min_in, max_ff, max_in;
   logic                found_ff, found_in;
   trts_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   trts_pkg::rsp_type   rsp_ff, rsp_in;
   logic                div_start;
   logic                div_busy;
   logic [DivW-1:0]     quotient;
   logic [SumW-1:0]     sum_mag;
   logic                rec_ok, date_eq, take;
   logic [15:0]         q16;

   // record check and entry match against the latched request
   always_comb begin
      rec_ok = (req_ff.rec_month >= 8'd1) && (req_ff.rec_month <= 8'd12) &&
               (req_ff.rec_day >= 8'd1) && (req_ff.rec_day <= 8'd31) &&
               (req_ff.rec_hour <= 8'd23) && (req_ff.rec_minute <= 8'd59) &&
               (req_ff.rec_temp >= -8'sd99) && (req_ff.rec_temp <= 8'sd99);
      date_eq = (rd_ff.year == req_ff.rec_year) &&
                ({4'd0, rd_ff.month} == req_ff.rec_month) &&
                ({3'd0, rd_ff.day} == req_ff.rec_day) &&
                ({3'd0, rd_ff.hour} == req_ff.rec_hour) &&
                ({2'd0, rd_ff.minute} == req_ff.rec_minute);
      take = (req_ff.action == trts_pkg::ACT_ALL) ||
             ({4'd0, rd_ff.month} == req_ff.rec_month);
      // the divide starts on the last scan step, so take the updated sum
      sum_mag = sum_in[SumW-1] ? SumW'(-sum_in) : SumW'(sum_in);
      q16 = quotient[15:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trts_pkg::S_IDLE:
            if (req_valid && !req_stall) state_in = trts_pkg::S_DECODE;
         trts_pkg::S_DECODE: begin
            unique case (req_ff.action)
               trts_pkg::ACT_PUSH_BACK:
                  state_in = (rec_ok && count_ff < CntW'(TABLE_DEPTH)) ?
                             trts_pkg::S_WRITE : trts_pkg::S_DONE;
               trts_pkg::ACT_PUSH_FRONT:
                  state_in = !(rec_ok && count_ff < CntW'(TABLE_DEPTH)) ?
                             trts_pkg::S_DONE :
                             (count_ff == '0) ? trts_pkg::S_WRITE : trts_pkg::S_SHIFT_RD;
               trts_pkg::ACT_REMOVE, trts_pkg::ACT_MONTH, trts_pkg::ACT_ALL:
                  state_in = (count_ff == '0) ? trts_pkg::S_DONE : trts_pkg::S_SCAN_RD;
               default: state_in = trts_pkg::S_DONE;
            endcase
         end
         trts_pkg::S_SHIFT_RD: state_in = trts_pkg::S_SHIFT_WR;
         trts_pkg::S_SHIFT_WR:
            state_in = (idx_ff == CntW'(1)) ? trts_pkg::S_WRITE : trts_pkg::S_SHIFT_RD;
         trts_pkg::S_WRITE: state_in = trts_pkg::S_DONE;
         trts_pkg::S_SCAN_RD: state_in = trts_pkg::S_SCAN_CHK;
         trts_pkg::S_SCAN_CHK: begin
            if (idx_ff + CntW'(1) >= count_ff) begin
               if (req_ff.action == trts_pkg::ACT_REMOVE) state_in = trts_pkg::S_DONE;
               else if (mcnt_in == '0) state_in = trts_pkg::S_DONE;
               else state_in = trts_pkg::S_DIV;
            end else begin
               state_in = trts_pkg::S_SCAN_RD;
            end
         end
         trts_pkg::S_DIV:
            if (!div_busy && !div_start) state_in = trts_pkg::S_DONE;
         trts_pkg::S_DONE:
            if (!rsp_valid_ff || !rsp_stall) state_in = trts_pkg::S_IDLE;
         default: state_in = trts_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      mcnt_in = mcnt_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      found_in = found_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      mem_addr = '0;
      mem_we = 1'b0;
      mem_wd.year = req_ff.rec_year;
      mem_wd.month = req_ff.rec_month[3:0];
      mem_wd.day = req_ff.rec_day[4:0];
      mem_wd.hour = req_ff.rec_hour[4:0];
      mem_wd.minute = req_ff.rec_minute[5:0];
      mem_wd.temp = req_ff.rec_temp;
      div_start = 1'b0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         trts_pkg::S_IDLE: begin
            if (req_valid && !req_stall) req_in = req;
            idx_in = '0;
            mcnt_in = '0;
            sum_in = '0;
            min_in = 8'sd127;
            max_in = -8'sd128;
            found_in = 1'b0;
         end
         trts_pkg::S_DECODE: begin
            status_in = trts_pkg::ST_OK;
            unique case (req_ff.action)
               trts_pkg::ACT_PUSH_BACK, trts_pkg::ACT_PUSH_FRONT: begin
                  if (!rec_ok) status_in = trts_pkg::ST_INVALID;
                  else if (count_ff >= CntW'(TABLE_DEPTH)) status_in = trts_pkg::ST_FULL;
                  idx_in = (req_ff.action == trts_pkg::ACT_PUSH_BACK) ? count_ff : count_ff;
               end
               trts_pkg::ACT_REMOVE:
                  if (count_ff == '0) status_in = trts_pkg::ST_NOT_FOUND;
               trts_pkg::ACT_MONTH, trts_pkg::ACT_ALL:
                  if (count_ff == '0) status_in = trts_pkg::ST_EMPTY;
               default: status_in = trts_pkg::ST_INVALID;
            endcase
         end
         trts_pkg::S_SHIFT_RD: mem_addr = AddrW'(idx_ff - CntW'(1));
         trts_pkg::S_SHIFT_WR: begin
            mem_addr = AddrW'(idx_ff);
            mem_we = 1'b1;
            mem_wd = rd_ff;
            idx_in = idx_ff - CntW'(1);
         end
         trts_pkg::S_WRITE: begin
            mem_addr = (req_ff.action == trts_pkg::ACT_PUSH_BACK) ? AddrW'(count_ff) : '0;
            mem_we = 1'b1;
            count_in = count_ff + CntW'(1);
         end
         trts_pkg::S_SCAN_RD: mem_addr = AddrW'(idx_ff);
         trts_pkg::S_SCAN_CHK: begin
            if (req_ff.action == trts_pkg::ACT_REMOVE) begin
               // once found, copy entry idx into slot idx-1
               if (found_ff) begin
                  mem_addr = AddrW'(idx_ff - CntW'(1));
                  mem_we = 1'b1;
                  mem_wd = rd_ff;
               end else if (date_eq) begin
                  found_in = 1'b1;
               end
               if (idx_ff + CntW'(1) >= count_ff) begin
                  if (found_in) count_in = count_ff - CntW'(1);
                  else status_in = trts_pkg::ST_NOT_FOUND;
               end
            end else if (take) begin
               mcnt_in = mcnt_ff + CntW'(1);
               sum_in = sum_ff + SumW'(rd_ff.temp);
               if (rd_ff.temp < min_ff) min_in = rd_ff.temp;
               if (rd_ff.temp > max_ff) max_in = rd_ff.temp;
            end
            if (req_ff.action != trts_pkg::ACT_REMOVE && idx_ff + CntW'(1) >= count_ff) begin
               if (mcnt_in == '0) status_in = trts_pkg::ST_EMPTY;
               else div_start = 1'b1;
            end
            idx_in = idx_ff + CntW'(1);
         end
         trts_pkg::S_DIV: ;
         trts_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.match_count = 7'(mcnt_ff);
               rsp_in.min_temp = min_ff;
               rsp_in.max_temp = max_ff;
               if (mcnt_ff == '0) rsp_in.avg_temp = '0;
               else rsp_in.avg_temp = sum_ff[SumW-1] ? 16'(-q16) : q16;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trts_pkg::S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      mcnt_ff <= mcnt_in;
      sum_ff <= sum_in;
      min_ff <= min_in;
      max_ff <= max_in;
      found_ff <= found_in;
      status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   trts_divider #(.CntW(CntW), .DivW(DivW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_mag[SumW-2:0], 8'd0}),
      .divisor  (mcnt_ff + ((state_ff == trts_pkg::S_SCAN_CHK && take) ? CntW'(1) : '0)),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != trts_pkg::S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `TRTS_ASSERT(a_count_max, clock, reset, count_ff <= CntW'(TABLE_DEPTH), "count over depth")
   `TRTS_ASSERT(a_idle_stall, clock, reset, (state_ff != trts_pkg::S_IDLE) |-> req_stall, "ready while busy")
   `TRTS_ASSERT(a_one_out, clock, reset, (req_valid && !req_stall) |=> !rsp_valid, "result with no work")
endmodule
